[rtl/core/sfn_pkg.sv]
package sfn_pkg;

  localparam int unsigned BaseLen = 8;
  localparam int unsigned ExtLen  = 3;
  localparam int unsigned NameLen = BaseLen + ExtLen;

  localparam logic [7:0] PAD_BYTE = 8'h20;
  localparam logic [7:0] DOT_BYTE = 8'h2E;
  localparam logic [7:0] LOWER_A  = 8'h61;
  localparam logic [7:0] LOWER_Z  = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // Action codes carried in the input transaction
  localparam logic ACT_CHAR   = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] ch;
  } char_t;

  typedef struct packed {
    logic [7:0] base_0;
    logic [7:0] base_1;
    logic [7:0] base_2;
    logic [7:0] base_3;
    logic [7:0] base_4;
    logic [7:0] base_5;
    logic [7:0] base_6;
    logic [7:0] base_7;
    logic [7:0] ext_0;
    logic [7:0] ext_1;
    logic [7:0] ext_2;
  } name_t;

  // Builder counters, visible to the top level for checking
  typedef struct packed {
    logic [3:0] base_count;
    logic [1:0] ext_count;
    logic       dot_seen;
  } status_t;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    if (c >= LOWER_A && c <= LOWER_Z) begin
      return c - CASE_GAP;
    end
    return c;
  endfunction

endpackage

[rtl/core/sfn_builder.sv]
module sfn_builder (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  sfn_pkg::char_t   item,
  output sfn_pkg::name_t   name,
  output sfn_pkg::status_t status
);

  logic [sfn_pkg::NameLen-1:0][7:0] name_bytes;
  logic [sfn_pkg::NameLen-1:0][7:0] name_bytes_next;
  logic [3:0] base_count;
  logic [3:0] base_count_next;
  logic [1:0] ext_count;
  logic [1:0] ext_count_next;
  logic       dot_seen;
  logic       dot_seen_next;
  logic [3:0] wr_idx;
  logic       wr_en;
  logic [7:0] up_ch;

  assign up_ch = sfn_pkg::to_upper(item.ch);

  // Next state for one transaction
  always_comb begin
    name_bytes_next = name_bytes;
    base_count_next = base_count;
    ext_count_next  = ext_count;
    dot_seen_next   = dot_seen;
    wr_en           = 1'b0;
    wr_idx          = base_count;
    if (item.action == sfn_pkg::ACT_FINISH) begin
      name_bytes_next = {sfn_pkg::NameLen{sfn_pkg::PAD_BYTE}};
      base_count_next = '0;
      ext_count_next  = '0;
      dot_seen_next   = 1'b0;
    end else if (!dot_seen) begin
      if (item.ch == sfn_pkg::DOT_BYTE) begin
        dot_seen_next = 1'b1;
      end else if (base_count < 4'(sfn_pkg::BaseLen)) begin
        wr_en           = 1'b1;
        wr_idx          = base_count;
        base_count_next = base_count + 4'd1;
      end
    end else if (ext_count < 2'(sfn_pkg::ExtLen)) begin
      wr_en          = 1'b1;
      wr_idx         = 4'(sfn_pkg::BaseLen) + {2'b00, ext_count};
      ext_count_next = ext_count + 2'd1;
    end
    if (wr_en) begin
      name_bytes_next[wr_idx] = up_ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_bytes <= {sfn_pkg::NameLen{sfn_pkg::PAD_BYTE}};
      base_count <= '0;
      ext_count  <= '0;
      dot_seen   <= 1'b0;
    end else if (step) begin
      name_bytes <= name_bytes_next;
      base_count <= base_count_next;
      ext_count  <= ext_count_next;
      dot_seen   <= dot_seen_next;
    end
  end

  // Byte 0 lands in the first struct field
  always_comb begin
    name.base_0 = name_bytes[0];
    name.base_1 = name_bytes[1];
    name.base_2 = name_bytes[2];
    name.base_3 = name_bytes[3];
    name.base_4 = name_bytes[4];
    name.base_5 = name_bytes[5];
    name.base_6 = name_bytes[6];
    name.base_7 = name_bytes[7];
    name.ext_0  = name_bytes[8];
    name.ext_1  = name_bytes[9];
    name.ext_2  = name_bytes[10];
  end

  assign status.base_count = base_count;
  assign status.ext_count  = ext_count;
  assign status.dot_seen   = dot_seen;

endmodule

[rtl/core/short_name_formatter_core.sv]
// Builds an 8.3 short name (8 base bytes, 3 extension bytes) from a stream
// of name characters.
// Input channel char_*: one transaction per character (action = char) or a
// finish (action = finish). Output channel name_*: one transaction per
// finish, carrying the 11 space-padded, upper-cased name bytes.
// Throughput: one input transaction per cycle while the output is free.
// Each transaction is held in the input register, then the builder updates
// its counters and at most one name byte; a finish loads the result register
// and clears the builder in the same cycle. A finish passes through the input
// register and then the result register before name_valid rises.
// The result register frees the input side: characters keep flowing while a
// result waits. Only a finish that meets a held result stalls, and then
// char_stall rises until name_stall drops.
// Reset (rst, synchronous): empties both registers and returns the name to
// eleven spaces with all counters at zero.
module short_name_formatter_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           char_valid,
  output logic           char_stall,
  input  sfn_pkg::char_t char_item,
  output logic           name_valid,
  input  logic           name_stall,
  output sfn_pkg::name_t name_item
);

  logic             in_valid;
  sfn_pkg::char_t   in_item;
  logic             advance;
  logic             step;
  logic             finish;
  sfn_pkg::name_t   name;
  sfn_pkg::status_t status;

  // Input register advances unless a finish is blocked by a held result
  assign finish     = in_valid && (in_item.action == sfn_pkg::ACT_FINISH);
  assign advance    = !(finish && name_valid && name_stall);
  assign step       = in_valid && advance;
  assign char_stall = in_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (advance) begin
      in_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && char_valid) begin
      in_item <= char_item;
    end
  end

  sfn_builder u_builder (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_item),
    .name   (name),
    .status (status)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      name_valid <= 1'b0;
    end else if (step && finish) begin
      name_valid <= 1'b1;
    end else if (!name_stall) begin
      name_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && finish) begin
      name_item <= name;
    end
  end

`ifndef ASSERT_OFF
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    step && finish |=> status.base_count == 4'd0 && status.ext_count == 2'd0
      && !status.dot_seen)
    else $error("builder not cleared after finish");

  a_base_bound: assert property (@(posedge clk) disable iff (rst)
    status.base_count <= 4'(sfn_pkg::BaseLen))
    else $error("base count past limit");

  a_ext_needs_dot: assert property (@(posedge clk) disable iff (rst)
    !status.dot_seen |-> status.ext_count == 2'd0)
    else $error("extension written before dot");

  a_stall_only_on_blocked_finish: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> finish && name_valid && name_stall)
    else $error("input stalled without a blocked finish");
`endif

endmodule

[sim/short_name_checker.sv]
module short_name_checker
  import sfn_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  char_valid,
  input  logic  char_stall,
  input  char_t char_item,
  input  logic  name_valid,
  input  logic  name_stall,
  input  name_t name_item,
  input  logic  run_done,
  output int    fail_count,
  output int    pending,
  output int    names_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the name being built
  logic [7:0] name_buf [NameLen];
  logic [3:0] base_fill;
  logic [1:0] ext_fill;
  logic       in_ext;

  name_t expected_names [$];

  string field_label [NameLen] = '{"base_0", "base_1", "base_2", "base_3", "base_4",
                                   "base_5", "base_6", "base_7", "ext_0", "ext_1",
                                   "ext_2"};

  function automatic logic [7:0] upper_case(input logic [7:0] c);
    if (c >= LOWER_A && c <= LOWER_Z) begin
      return c - CASE_GAP;
    end
    return c;
  endfunction

  task automatic clear_name();
    foreach (name_buf[k]) begin
      name_buf[k] = PAD_BYTE;
    end
    base_fill = '0;
    ext_fill  = '0;
    in_ext    = 1'b0;
  endtask

  // Byte 0 of the name sits in the top byte of the packed result
  function automatic name_t packed_name();
    logic [8*NameLen-1:0] flat;
    for (int k = 0; k < NameLen; k++) begin
      flat[8*(NameLen-k)-1 -: 8] = name_buf[k];
    end
    return flat;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("name check: %s at %0t ns", msg, $time);
    fail_count++;
  endtask

  // Advance the shadow builder by one transaction
  task automatic predict(input char_t it);
    if (it.action == ACT_FINISH) begin
      expected_names.push_back(packed_name());
      clear_name();
    end else if (!in_ext) begin
      if (it.ch == DOT_BYTE) begin
        in_ext = 1'b1;
      end else if (base_fill < BaseLen) begin
        name_buf[base_fill] = upper_case(it.ch);
        base_fill++;
      end
    end else if (ext_fill < ExtLen) begin
      name_buf[BaseLen + ext_fill] = upper_case(it.ch);
      ext_fill++;
    end
  endtask

  task automatic compare_name(input name_t got, input name_t want);
    logic [8*NameLen-1:0] g;
    logic [8*NameLen-1:0] w;
    g = got;
    w = want;
    for (int k = 0; k < NameLen; k++) begin
      if (g[8*(NameLen-k)-1 -: 8] !== w[8*(NameLen-k)-1 -: 8]) begin
        report_mismatch($sformatf("%s is %02h, expected %02h", field_label[k],
                                  g[8*(NameLen-k)-1 -: 8], w[8*(NameLen-k)-1 -: 8]));
      end
    end
  endtask

  initial begin
    fail_count    = 0;
    pending       = 0;
    names_checked = 0;
    clear_name();
  end

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      clear_name();
      expected_names.delete();
    end else begin
      if (name_valid && !name_stall) begin
        if (expected_names.size() == 0) begin
          report_mismatch("name transaction with no finish outstanding");
        end else begin
          compare_name(name_item, expected_names.pop_front());
          names_checked++;
        end
      end
      if (char_valid && !char_stall) begin
        predict(char_item);
      end
      // anything still queued at the end never came out
      if (run_done) begin
        while (expected_names.size() != 0) begin
          report_mismatch("expected name never delivered");
          void'(expected_names.pop_front());
        end
      end
    end
    pending = expected_names.size();
  end

endmodule

[sim/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfn_pkg::*;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS, STALL_TOGGLE} stall_mode_t;

  logic  clk;
  logic  rst;
  logic  char_valid;
  logic  char_stall;
  char_t char_item;
  logic  name_valid;
  logic  name_stall;
  name_t name_item;
  logic  run_done;

  int fail_count;
  int pending;
  int names_checked;

  int chars_sent;
  int finishes_sent;
  int burst_left;

  stall_mode_t stall_mode;
  int          mode_left;
  int          run_left;
  logic        run_hold;

  short_name_formatter_core dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item),
    .name_valid (name_valid),
    .name_stall (name_stall),
    .name_item  (name_item)
  );

  short_name_checker name_check (
    .clk           (clk),
    .rst           (rst),
    .char_valid    (char_valid),
    .char_stall    (char_stall),
    .char_item     (char_item),
    .name_valid    (name_valid),
    .name_stall    (name_stall),
    .name_item     (name_item),
    .run_done      (run_done),
    .fail_count    (fail_count),
    .pending       (pending),
    .names_checked (names_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver stall, switching between its own patterns
  initial begin
    name_stall = 1'b0;
    stall_mode = STALL_NONE;
    mode_left  = 0;
    run_left   = 0;
    run_hold   = 1'b0;
  end

  always @(negedge clk) begin
    if (rst) begin
      name_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(40, 200);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE: begin
          name_stall <= 1'b0;
        end
        STALL_RANDOM: begin
          name_stall <= ($urandom_range(0, 2) == 0);
        end
        STALL_RUNS: begin
          if (run_left == 0) begin
            run_hold = !run_hold;
            run_left = run_hold ? $urandom_range(1, 20) : $urandom_range(1, 6);
          end
          run_left--;
          name_stall <= run_hold;
        end
        default: begin
          name_stall <= !name_stall;
        end
      endcase
    end
  end

  // One transaction, in bursts with random gaps; starts and ends at a falling edge
  task automatic send_item(input char_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        char_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    char_valid <= 1'b1;
    char_item  <= it;
    do @(posedge clk); while (char_stall);
    if (it.action == ACT_FINISH) begin
      finishes_sent++;
    end else begin
      chars_sent++;
    end
    @(negedge clk);
  endtask

  task automatic send_char(input logic [7:0] c);
    char_t it;
    it.action = ACT_CHAR;
    it.ch     = c;
    send_item(it);
  endtask

  task automatic send_finish();
    char_t it;
    it.action = ACT_FINISH;
    it.ch     = 8'($urandom_range(0, 255));
    send_item(it);
  endtask

  // Hold the sender off until every name due has come out
  task automatic wait_names_drained(input int limit);
    int n;
    n = 0;
    char_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0 && n < limit) begin
      @(negedge clk);
      n++;
    end
  endtask

  // Mostly name-like bytes, with dots and any byte mixed in
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return LOWER_A + 8'($urandom_range(0, 25));
      4:          return 8'h41 + 8'($urandom_range(0, 25));
      5:          return DOT_BYTE;
      6:          return 8'h30 + 8'($urandom_range(0, 9));
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [7:0] mixed_name [$];
    char_t      noise;
    int         len;
    bit         paused;

    rst           = 1'b1;
    run_done      = 1'b0;
    char_valid    = 1'b0;
    char_item     = '0;
    chars_sent    = 0;
    finishes_sent = 0;
    burst_left    = 0;
    paused        = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty name: eleven spaces
    send_finish();

    // Case-fold boundaries, zero and 0xFF bytes, dots inside the extension,
    // and an extension that overflows on a dot
    mixed_name = '{LOWER_A, LOWER_Z, 8'h60, 8'h7B, 8'h00, 8'hFF,
                   DOT_BYTE, DOT_BYTE, 8'h71, DOT_BYTE, DOT_BYTE};
    foreach (mixed_name[k]) begin
      send_char(mixed_name[k]);
    end
    send_finish();

    // Base overflow, then a dot still opens the extension
    for (int k = 0; k < 9; k++) begin
      send_char(LOWER_A + 8'(k));
    end
    send_char(DOT_BYTE);
    send_char(8'h78);
    send_finish();

    // Random names, with some raw noise between them
    while (chars_sent + finishes_sent < 800) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          noise.action = ($urandom_range(0, 3) == 0) ? ACT_FINISH : ACT_CHAR;
          noise.ch     = 8'($urandom_range(0, 255));
          send_item(noise);
        end
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(0, 12);
        for (int k = 0; k < len; k++) begin
          send_char(pick_char());
        end
        send_finish();
      end
      if (!paused && chars_sent + finishes_sent >= 400) begin
        wait_names_drained(20000);
        paused = 1'b1;
      end
    end

    // Drain, wait for stray results, then flag leftovers
    wait_names_drained(20000);
    repeat (10) @(negedge clk);
    run_done <= 1'b1;
    repeat (2) @(negedge clk);

    $display("tb: drove %0d character and %0d finish transactions, compared %0d names",
             chars_sent, finishes_sent, names_checked);
    $display("tb: included empty names, case-fold edges, base and extension overflow");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/sfn_pkg.sv
rtl/core/sfn_builder.sv
rtl/core/short_name_formatter_core.sv
sim/short_name_checker.sv
sim/tb.sv
